/* rtl/core/abv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACPI blob validator package
// Shared constants, codes, signature lookup and the front-to-back event type.
// ----------------------------------------------------------------------------
package abv_pkg;

  localparam int unsigned HEADER_BYTES = 36;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrW        = $clog2(QDepth);
  localparam int unsigned QCntW        = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUF_SMALL = 3'd1,
    ST_LEN_OVER  = 3'd2,
    ST_CHECKSUM  = 3'd3,
    ST_SIGNATURE = 3'd4,
    ST_LEN_UNDER = 3'd5,
    ST_TRUNCATED = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    KIND_NFIT = 3'd0,
    KIND_PCAT = 3'd1,
    KIND_SRAT = 3'd2,
    KIND_HMAT = 3'd3,
    KIND_PMTT = 3'd4
  } kind_e;

  // Signatures as captured: byte 0 in the low bits
  localparam logic [31:0] SIG_NFIT = {8'h54, 8'h49, 8'h46, 8'h4E};
  localparam logic [31:0] SIG_PCAT = {8'h54, 8'h41, 8'h43, 8'h50};
  localparam logic [31:0] SIG_SRAT = {8'h54, 8'h41, 8'h52, 8'h53};
  localparam logic [31:0] SIG_HMAT = {8'h54, 8'h41, 8'h4D, 8'h48};
  localparam logic [31:0] SIG_PMTT = {8'h54, 8'h54, 8'h4D, 8'h50};

  typedef struct packed {
    logic  found;
    kind_e kind;
  } kind_hit_t;

  // One record request from the parser to the emitter
  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic [31:0] length;
    logic        final_rec;
  } evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic kind_hit_t sig_lookup(input logic [31:0] sig);
    kind_hit_t hit;
    hit.found = 1'b1;
    hit.kind  = KIND_NFIT;
    priority if (sig == SIG_NFIT) hit.kind = KIND_NFIT;
    else if (sig == SIG_PCAT)     hit.kind = KIND_PCAT;
    else if (sig == SIG_SRAT)     hit.kind = KIND_SRAT;
    else if (sig == SIG_HMAT)     hit.kind = KIND_HMAT;
    else if (sig == SIG_PMTT)     hit.kind = KIND_PMTT;
    else                          hit.found = 1'b0;
    return hit;
  endfunction

endpackage

/* rtl/core/abv_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACPI blob validator channels
// Byte input, record output and configuration write channels.
// ----------------------------------------------------------------------------
interface abv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface abv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  table_kind;
  logic [31:0] start_offset;
  logic [31:0] end_offset;
  logic [2:0]  status;
  logic        final_record;

  modport source (output valid, output table_kind, output start_offset,
                  output end_offset, output status, output final_record,
                  input ready);
  modport sink   (input valid, input table_kind, input start_offset,
                  input end_offset, input status, input final_record,
                  output ready);
endinterface

interface abv_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] buffer_length;

  modport source (output valid, output buffer_length, input ready);
  modport sink   (input valid, input buffer_length, output ready);
endinterface

/* rtl/core/abv_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACPI blob validator parser
// Tracks header fields, byte sum and error hold; classifies each byte and
// pushes a record request when a table ends or an error is found.
// ----------------------------------------------------------------------------
module abv_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  abv_in_if.sink               in_ch,
  input  logic [31:0]          buf_len_i,
  input  abv_pkg::q_stat_t     q_stat_i,
  output logic                 push_o,
  output abv_pkg::evt_t        push_evt_o
);
  import abv_pkg::*;

  logic [31:0] bit_q, bit_d;
  logic [31:0] len_q, len_d;
  logic [31:0] sig_q, sig_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] seen_q, seen_d;
  logic        hold_q, hold_d;

  logic        accept;
  logic        upd;
  logic        emit;
  logic        tbl_done;
  status_e     st;
  logic [31:0] bit_inc;
  logic [31:0] len_n;
  logic [31:0] sig_n;
  logic [7:0]  sum_n;
  logic [4:0]  shamt;
  kind_hit_t   hit;

  assign in_ch.ready = !q_stat_i.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign bit_inc     = bit_q + 32'd1;
  assign sum_n       = sum_q + in_ch.data_byte;
  assign shamt       = {bit_q[1:0], 3'b000};
  assign hit         = sig_lookup(sig_q);

  always_comb begin
    len_n    = len_q;
    sig_n    = sig_q;
    upd      = 1'b0;
    emit     = 1'b0;
    tbl_done = 1'b0;
    st       = ST_OK;
    if (!hold_q) begin
      if (seen_q == 32'd0 && buf_len_i < 32'(HEADER_BYTES)) begin
        emit = 1'b1;
        st   = ST_BUF_SMALL;
      end else begin
        upd = 1'b1;
        if (bit_q[31:2] == 30'd0) begin
          sig_n = sig_q | ({24'd0, in_ch.data_byte} << shamt);
        end else if (bit_q[31:3] == 29'd0) begin
          len_n = len_q | ({24'd0, in_ch.data_byte} << shamt);
        end
        if (bit_q[31:3] != 29'd0 || bit_q[2:0] == 3'd7) begin
          priority if (bit_q == 32'd7 && len_n < 32'd8) begin
            emit = 1'b1;
            st   = ST_LEN_UNDER;
          end else if (bit_q == 32'd7 && buf_len_i < len_n) begin
            emit = 1'b1;
            st   = ST_LEN_OVER;
          end else if (bit_inc == len_n) begin
            emit = 1'b1;
            priority if (sum_n != 8'd0) st = ST_CHECKSUM;
            else if (!hit.found)        st = ST_SIGNATURE;
            else                        tbl_done = 1'b1;
          end else begin
            emit = 1'b0;
          end
        end
      end
      if (!emit && in_ch.end_of_buffer) begin
        emit = 1'b1;
        st   = ST_TRUNCATED;
      end
    end
  end

  always_comb begin
    bit_d  = bit_q;
    len_d  = len_q;
    sig_d  = sig_q;
    sum_d  = sum_q;
    seen_d = seen_q;
    hold_d = hold_q;
    if (accept) begin
      if (in_ch.end_of_buffer) begin
        // blob ends: return to the fresh stream state
        bit_d  = '0;
        len_d  = '0;
        sig_d  = '0;
        sum_d  = '0;
        seen_d = '0;
        hold_d = 1'b0;
      end else if (!hold_q) begin
        seen_d = seen_q + 32'd1;
        if (upd) begin
          bit_d = bit_inc;
          len_d = len_n;
          sig_d = sig_n;
          sum_d = sum_n;
        end
        if (tbl_done) begin
          bit_d = '0;
          len_d = '0;
          sig_d = '0;
          sum_d = '0;
        end
        if (emit && st != ST_OK) hold_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      len_q  <= '0;
      sig_q  <= '0;
      sum_q  <= '0;
      seen_q <= '0;
      hold_q <= 1'b0;
    end else begin
      bit_q  <= bit_d;
      len_q  <= len_d;
      sig_q  <= sig_d;
      sum_q  <= sum_d;
      seen_q <= seen_d;
      hold_q <= hold_d;
    end
  end

  assign push_o               = accept && !hold_q && emit;
  assign push_evt_o.status    = st;
  assign push_evt_o.kind      = (st == ST_OK) ? hit.kind : KIND_NFIT;
  assign push_evt_o.length    = len_n;
  assign push_evt_o.final_rec = in_ch.end_of_buffer || (st != ST_OK);

endmodule

/* rtl/core/abv_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACPI blob validator event queue
// Short queue of record requests between the parser and the emitter.
// ----------------------------------------------------------------------------
module abv_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  abv_pkg::evt_t     push_evt_i,
  input  logic              pop_i,
  output abv_pkg::evt_t     pop_evt_o,
  output abv_pkg::q_stat_t  stat_o
);
  import abv_pkg::*;

  evt_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_evt_o    = slot_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QCntW'(1);
      2'b01:   cnt_d = cnt_q - QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= push_evt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/core/abv_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACPI blob validator record emitter
// Keeps the cumulative table length and builds the registered output records.
// ----------------------------------------------------------------------------
module abv_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abv_pkg::evt_t     evt_i,
  input  abv_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  abv_out_if.source         out_ch
);
  import abv_pkg::*;

  logic [31:0] cum_q, cum_d;
  logic        vld_q, vld_d;
  kind_e       kind_q, kind_d;
  status_e     st_q, st_d;
  logic [31:0] start_q, start_d;
  logic [31:0] end_q, end_d;
  logic        fin_q, fin_d;
  logic [31:0] cum_sum;

  assign pop_o   = !q_stat_i.empty && (!vld_q || out_ch.ready);
  assign cum_sum = cum_q + evt_i.length;

  always_comb begin
    cum_d   = cum_q;
    vld_d   = vld_q && !out_ch.ready;
    kind_d  = kind_q;
    st_d    = st_q;
    start_d = start_q;
    end_d   = end_q;
    fin_d   = fin_q;
    if (pop_o) begin
      vld_d  = 1'b1;
      st_d   = evt_i.status;
      fin_d  = evt_i.final_rec;
      kind_d = evt_i.kind;
      if (evt_i.status == ST_OK) begin
        start_d = 32'(HEADER_BYTES) + cum_q;
        end_d   = cum_sum;
        cum_d   = cum_sum;
      end else begin
        start_d = '0;
        end_d   = '0;
      end
      // the stream restarts after any final record
      if (evt_i.final_rec) cum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cum_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cum_q <= cum_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    st_q    <= st_d;
    start_q <= start_d;
    end_q   <= end_d;
    fin_q   <= fin_d;
  end

  assign out_ch.valid        = vld_q;
  assign out_ch.table_kind   = kind_q;
  assign out_ch.start_offset = start_q;
  assign out_ch.end_offset   = end_q;
  assign out_ch.status       = st_q;
  assign out_ch.final_record = fin_q;

endmodule

/* rtl/core/acpi_table_blob_validator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACPI table blob validator
// Checks a stream of concatenated ACPI tables and reports one record per
// table end or error.
// ----------------------------------------------------------------------------
// Usage: write buffer_length on cfg_ch while idle, then stream the blob one
// byte per in_ch beat, end_of_buffer set on the last byte. out_ch carries one
// record per completed table (kind, data start and end offsets) and one per
// error; after an error the remaining bytes are absorbed up to end_of_buffer.
// Throughput: one byte per cycle while in_ch.ready is high. The parser takes each
// byte as it is accepted; records pass a four-entry queue and a registered emitter
// stage, so a record is written into the queue and then into the output register.
// in_ch.ready drops only when the queue is full, which happens only after the
// receiver has held out_ch.ready low long enough to back up four records plus
// the output register. cfg_ch is always ready.
// Reset clears all stream state and buffer_length to zero; the queue empties.
// ----------------------------------------------------------------------------
module acpi_table_blob_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  abv_cfg_if.sink    cfg_ch,
  abv_in_if.sink     in_ch,
  abv_out_if.source  out_ch
);
  import abv_pkg::*;

  logic [31:0] buf_len_q;
  logic        push;
  logic        pop;
  evt_t        push_evt;
  evt_t        pop_evt;
  q_stat_t     q_stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      buf_len_q <= cfg_ch.buffer_length;
    end
  end

  abv_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .buf_len_i  (buf_len_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_evt_o (push_evt)
  );

  abv_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_evt_i (push_evt),
    .pop_i      (pop),
    .pop_evt_o  (pop_evt),
    .stat_o     (q_stat)
  );

  abv_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (pop_evt),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_ch   (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("record pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("record popped from an empty queue");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.status != ST_OK) |->
      (out_ch.start_offset == 32'd0 && out_ch.end_offset == 32'd0 &&
       out_ch.table_kind == KIND_NFIT && out_ch.final_record))
    else $error("error record carries nonzero fields");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> !$past(pop))
    else $error("emitter popped while output stalled");

endmodule

/* bench/abv_blob_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACPI blob validator scoreboard
// Watches the configuration, byte and record channels, predicts the records of
// the accepted bytes from its own copy of the parser state and compares each
// record beat field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module abv_blob_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_buffer_length_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_byte_i,
  input  logic        in_end_of_buffer_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  out_table_kind_i,
  input  logic [31:0] out_start_offset_i,
  input  logic [31:0] out_end_offset_i,
  input  logic [2:0]  out_status_i,
  input  logic        out_final_record_i,
  output int          errors_o,
  output int          pending_o,
  output int          parsed_o,
  output int          records_o,
  output int          tables_o,
  output logic [7:0]  status_seen_o
);
  import abv_pkg::*;

  typedef struct packed {
    logic [2:0]  table_kind;
    logic [31:0] start_off;
    logic [31:0] end_off;
    logic [2:0]  status;
    logic        final_rec;
  } blob_record_t;

  blob_record_t pending_records[$];

  // Parser copy
  logic [31:0] buf_len;
  logic [31:0] pos_in_table;
  logic [31:0] table_len;
  logic [31:0] sig_bytes;
  logic [7:0]  byte_sum;
  logic [31:0] cum_len;
  logic [31:0] blob_bytes;
  logic        err_hold;

  int errors;
  int parsed;
  int records;
  int tables;
  logic [7:0] status_seen;

  task automatic clear_table();
    pos_in_table = '0;
    table_len    = '0;
    sig_bytes    = '0;
    byte_sum     = '0;
  endtask

  task automatic clear_stream();
    clear_table();
    cum_len    = '0;
    blob_bytes = '0;
    err_hold   = 1'b0;
  endtask

  task automatic parse_blob_byte(input logic [7:0] b, input logic eob);
    blob_record_t rec;
    logic         emit;
    logic         found;
    logic [2:0]   kind;
    logic [31:0]  idx;
    rec  = '0;
    emit = 1'b0;
    if (err_hold) begin
      // absorb the rest of the blob
      if (eob) clear_stream();
      return;
    end
    parsed++;
    rec.status = ST_OK;
    if (blob_bytes == 0 && buf_len < HEADER_BYTES) begin
      emit       = 1'b1;
      rec.status = ST_BUF_SMALL;
    end else begin
      idx      = pos_in_table;
      byte_sum = byte_sum + b;
      if (idx < 4) sig_bytes = sig_bytes | (32'(b) << (8 * idx));
      else if (idx < 8) table_len = table_len | (32'(b) << (8 * (idx - 4)));
      pos_in_table = idx + 32'd1;
      if (idx >= 7) begin
        if (idx == 7 && table_len < 8) begin
          emit       = 1'b1;
          rec.status = ST_LEN_UNDER;
        end else if (idx == 7 && buf_len < table_len) begin
          emit       = 1'b1;
          rec.status = ST_LEN_OVER;
        end else if ((idx + 32'd1) == table_len) begin
          emit  = 1'b1;
          found = 1'b1;
          case (sig_bytes)
            SIG_NFIT: kind = KIND_NFIT;
            SIG_PCAT: kind = KIND_PCAT;
            SIG_SRAT: kind = KIND_SRAT;
            SIG_HMAT: kind = KIND_HMAT;
            SIG_PMTT: kind = KIND_PMTT;
            default: begin
              found = 1'b0;
              kind  = KIND_NFIT;
            end
          endcase
          // checksum takes precedence over signature
          if (byte_sum != 0) rec.status = ST_CHECKSUM;
          else if (!found) rec.status = ST_SIGNATURE;
          else begin
            rec.table_kind = kind;
            rec.start_off  = HEADER_BYTES + cum_len;
            cum_len        = cum_len + table_len;
            rec.end_off    = cum_len;
            clear_table();
          end
        end
      end
      if (!emit && eob) begin
        emit       = 1'b1;
        rec.status = ST_TRUNCATED;
      end
    end
    blob_bytes = blob_bytes + 32'd1;
    if (eob) clear_stream();
    else if (emit && rec.status != ST_OK) err_hold = 1'b1;
    if (emit) begin
      rec.final_rec = eob || (rec.status != ST_OK);
      pending_records.insert(pending_records.size(), rec);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blob_record_t want;
    if (!rst_ni) begin
      buf_len = '0;
      clear_stream();
      pending_records.delete();
      errors      = 0;
      parsed      = 0;
      records     = 0;
      tables      = 0;
      status_seen = '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_records.size() == 0) begin
          errors++;
          $error("record beat with no prediction: status %0d kind %0d",
                 out_status_i, out_table_kind_i);
        end else begin
          want = pending_records.pop_front();
          records++;
          status_seen[out_status_i] = 1'b1;
          if (out_status_i == ST_OK) tables++;
          if (out_table_kind_i !== want.table_kind) begin
            errors++;
            $error("table_kind: expected %0d, got %0d", want.table_kind, out_table_kind_i);
          end
          if (out_start_offset_i !== want.start_off) begin
            errors++;
            $error("start_offset: expected %0d, got %0d",
                   want.start_off, out_start_offset_i);
          end
          if (out_end_offset_i !== want.end_off) begin
            errors++;
            $error("end_offset: expected %0d, got %0d",
                   want.end_off, out_end_offset_i);
          end
          if (out_status_i !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, out_status_i);
          end
          if (out_final_record_i !== want.final_rec) begin
            errors++;
            $error("final_record: expected %0d, got %0d", want.final_rec, out_final_record_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) buf_len = cfg_buffer_length_i;
      if (in_valid_i && in_ready_i) parse_blob_byte(in_data_byte_i, in_end_of_buffer_i);
    end
    errors_o      <= errors;
    pending_o     <= pending_records.size();
    parsed_o      <= parsed;
    records_o     <= records;
    tables_o      <= tables;
    status_seen_o <= status_seen;
  end

endmodule

/* bench/tb_acpi_table_blob_validator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACPI table blob validator testbench
// Streams directed and random table blobs (clean, damaged and noise) under
// several idle and stall mixes, reprograms buffer_length between blobs, and
// leaves record checking to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module tb_acpi_table_blob_validator;
  import abv_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_BYTES  = 310;
  localparam int DRAIN_CYCLES = 4;

  logic clk_i;
  logic rst_ni;

  abv_cfg_if cfg_ch();
  abv_in_if  in_ch();
  abv_out_if out_ch();

  acpi_table_blob_validator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int         errors;
  int         pending;
  int         parsed;
  int         records;
  int         tables;
  logic [7:0] status_seen;

  abv_blob_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_ch.valid),
    .cfg_ready_i         (cfg_ch.ready),
    .cfg_buffer_length_i (cfg_ch.buffer_length),
    .in_valid_i          (in_ch.valid),
    .in_ready_i          (in_ch.ready),
    .in_data_byte_i      (in_ch.data_byte),
    .in_end_of_buffer_i  (in_ch.end_of_buffer),
    .out_valid_i         (out_ch.valid),
    .out_ready_i         (out_ch.ready),
    .out_table_kind_i    (out_ch.table_kind),
    .out_start_offset_i  (out_ch.start_offset),
    .out_end_offset_i    (out_ch.end_offset),
    .out_status_i        (out_ch.status),
    .out_final_record_i  (out_ch.final_record),
    .errors_o            (errors),
    .pending_o           (pending),
    .parsed_o            (parsed),
    .records_o           (records),
    .tables_o            (tables),
    .status_seen_o       (status_seen)
  );

  int          src_idle_pct;
  int          snk_stall_pct;
  int          cycle_count;
  int          bytes_sent;
  int          blobs;
  logic [31:0] cur_buf;
  logic [31:0] max_len;
  logic [7:0]  blob_q[$];

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i) out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("acpi_table_blob_validator verification failed");
    $finish;
  end

  function automatic logic [31:0] pick_sig(input int k);
    case (k)
      0:       return SIG_NFIT;
      1:       return SIG_PCAT;
      2:       return SIG_SRAT;
      3:       return SIG_HMAT;
      default: return SIG_PMTT;
    endcase
  endfunction

  // Append one table: header, body capped for huge lengths, optional sum fix
  task automatic add_table(input logic [31:0] sig, input logic [31:0] len, input bit fix);
    int         body;
    logic [7:0] sum;
    logic [7:0] b;
    sum  = 8'd0;
    body = (len > 32'd320) ? 24 : ((len > 32'd8) ? int'(len) - 8 : 0);
    for (int n = 0; n < 4; n++) begin
      blob_q.insert(blob_q.size(), sig[8*n +: 8]);
      sum += sig[8*n +: 8];
    end
    for (int n = 0; n < 4; n++) begin
      blob_q.insert(blob_q.size(), len[8*n +: 8]);
      sum += len[8*n +: 8];
    end
    for (int n = 0; n < body; n++) begin
      b = 8'($urandom);
      blob_q.insert(blob_q.size(), b);
      sum += b;
    end
    if (fix && body > 0) blob_q[blob_q.size()-1] = blob_q[blob_q.size()-1] - sum;
    if (len > max_len) max_len = len;
  endtask

  task automatic wait_for_drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_buffer_length(input logic [31:0] v);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.buffer_length <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_buf = v;
  endtask

  task automatic push_byte(input logic [7:0] d, input logic last);
    logic drain_now;
    drain_now = ($urandom_range(399) == 0);
    if (drain_now || $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      // occasionally hold off until every record is out
      if (drain_now) wait_for_drain();
      else do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= d;
    in_ch.end_of_buffer <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_blob();
    for (int n = 0; n < blob_q.size(); n++) push_byte(blob_q[n], n == blob_q.size() - 1);
    in_ch.valid <= 1'b0;
    blobs++;
  endtask

  initial begin
    int          goal;
    int          mode;
    int          ntab;
    int          cut;
    int          r;
    int          idx;
    logic [31:0] len;
    rst_ni               = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.buffer_length = '0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.end_of_buffer  = 1'b0;
    out_ch.ready         = 1'b0;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    cycle_count          = 0;
    bytes_sent           = 0;
    blobs                = 0;
    cur_buf              = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: buffer too small on a one-byte blob and on a longer one
    set_buffer_length(32'd0);
    blob_q = '{8'hFF};
    send_blob();
    set_buffer_length(HEADER_BYTES - 1);
    blob_q = '{8'h00, 8'hFF};
    send_blob();
    // Length under 8 reported on the last byte of the blob
    set_buffer_length(32'hFFFF_FFFF);
    blob_q.delete();
    add_table(SIG_PMTT, 32'd5, 1'b0);
    send_blob();
    // Good table, then the blob stops inside the next header
    set_buffer_length(HEADER_BYTES);
    blob_q.delete();
    add_table(SIG_PCAT, 32'd9, 1'b1);
    blob_q.insert(blob_q.size(), 8'h48);
    blob_q.insert(blob_q.size(), 8'h4D);
    blob_q.insert(blob_q.size(), 8'h41);
    send_blob();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 59; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 59; end
        default: begin src_idle_pct = 21; snk_stall_pct = 21; end
      endcase
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) begin
        blob_q.delete();
        max_len = '0;
        mode    = $urandom_range(99);
        if (mode < 85) begin
          ntab = $urandom_range(1, 4);
          for (int t = 0; t < ntab; t++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(65, 200) : $urandom_range(8, 48);
            add_table(pick_sig($urandom_range(4)), len, 1'b1);
          end
          if (mode >= 55) begin
            case ($urandom_range(5))
              0: begin
                idx = $urandom_range(blob_q.size() - 1);
                blob_q[idx] = blob_q[idx] ^ 8'($urandom_range(1, 255));
              end
              1: begin
                cut = $urandom_range(1, (blob_q.size() > 20) ? 20 : blob_q.size() - 1);
                repeat (cut) void'(blob_q.pop_back());
              end
              2: repeat ($urandom_range(1, 12)) blob_q.insert(blob_q.size(), 8'($urandom));
              3: add_table($urandom, $urandom_range(9, 40), 1'b1);
              4: add_table(pick_sig($urandom_range(4)), $urandom_range(0, 7), 1'b0);
              default: begin
                len = ($urandom_range(1) == 0) ? $urandom_range(301, 2000) : $urandom;
                add_table(pick_sig($urandom_range(4)), len, 1'b0);
              end
            endcase
          end
        end else begin
          repeat ($urandom_range(1, 40)) blob_q.insert(blob_q.size(), 8'($urandom));
        end

        r = $urandom_range(99);
        if (r < 35) begin
          // keep the current buffer_length
        end else if (r < 60) set_buffer_length(blob_q.size());
        else if (r < 75) set_buffer_length(32'hFFFF_FFFF);
        else if (r < 85) set_buffer_length($urandom_range(HEADER_BYTES, 400));
        else if (r < 90) set_buffer_length($urandom_range(0, HEADER_BYTES - 1));
        else if (r < 95 && max_len > HEADER_BYTES) set_buffer_length(max_len - 1);
        else set_buffer_length($urandom);
        send_blob();
      end
    end

    wait_for_drain();
    repeat (2 * DRAIN_CYCLES) @(posedge clk_i);
    $display("streamed %0d bytes (%0d parsed) in %0d blobs under four idle/stall mixes",
             bytes_sent, parsed, blobs);
    $display("checked %0d records, %0d good tables, status codes seen %b",
             records, tables, status_seen);
    if (errors == 0 && pending == 0) begin
      $display("acpi_table_blob_validator verification clean");
    end else begin
      $display("acpi_table_blob_validator verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/abv_pkg.sv
rtl/core/abv_if.sv
rtl/core/abv_parse.sv
rtl/core/abv_fifo.sv
rtl/core/abv_emit.sv
rtl/core/acpi_table_blob_validator.sv
bench/abv_blob_checker.sv
bench/tb_acpi_table_blob_validator.sv
